>>> rtl/core/max_key_extract_table_top_assert.svh
// Assertion macros used by the max-key extract table RTL.
// Each macro expects clk and rst_n to be visible in the calling scope.
`ifndef MAX_KEY_EXTRACT_TABLE_TOP_ASSERT_SVH
`define MAX_KEY_EXTRACT_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define MKET_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define MKET_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/mket_pkg.sv
package mket_pkg;

    localparam int KEY_W = 16;
    localparam int TAG_W = 16;

    // Request codes
    localparam logic REQ_INSERT  = 1'b0;
    localparam logic REQ_EXTRACT = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_EXTRACTED = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_END,
        S_SHIFT_INIT,
        S_SHIFT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic ins;
        logic res_full;
        logic res_empty;
        logic scan_init;
        logic rd_issue;
        logic ptr_dec;
        logic ptr_inc;
        logic cmp_en;
        logic shift_init;
        logic shift_en;
        logic finish;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic full;
        logic empty;
        logic ptr_zero;
        logic ptr_lt_cnt;
        logic rd_pend;
    } stat_t;

endpackage

>>> rtl/core/max_key_extract_table_top.sv
// Max-key extract table: a bounded store of (key, tag) entries kept in
// insertion order, with insert and extract-max requests.
// Request channel: an item is taken at a rising edge with start high and busy
// low; req_type selects insert (key and tag stored) or extract.
// Result channel: done is high for exactly one cycle with status, out_key,
// out_tag and entry_count; the receiver must take it, there is no stall.
// Inserts, inserts into a full table and extracts from an empty table
// give a registered result beat in the cycle after the accept, and busy
// stays low, so a request may follow every cycle.
// An extract with N entries held and the winner at position p runs one
// compare per entry through the single store read port, then closes the
// gap by moving each newer entry down one place, one per cycle; busy stays
// high throughout and falls as the result beat appears.
// Among equal keys the newest entry is returned.
// Reset empties the table at once; no clearing pass is needed.
module max_key_extract_table_top #(
    parameter int CAPACITY = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        req_type,
    input  logic [mket_pkg::KEY_W-1:0]  key,
    input  logic [mket_pkg::TAG_W-1:0]  tag,
    output logic                        done,
    output logic [1:0]                  status,
    output logic [mket_pkg::KEY_W-1:0]  out_key,
    output logic [mket_pkg::TAG_W-1:0]  out_tag,
    output logic [6:0]                  entry_count
);

    mket_pkg::cmd_t  cmd;
    mket_pkg::stat_t stat;

    mket_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    mket_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .key         (key),
        .tag         (tag),
        .stat        (stat),
        .done        (done),
        .status      (status),
        .out_key     (out_key),
        .out_tag     (out_tag),
        .entry_count (entry_count)
    );

endmodule

>>> rtl/core/mket_ram.sv
module mket_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one port, read the other with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/mket_ctrl.sv
module mket_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            req_type,
    input  mket_pkg::stat_t stat,
    output mket_pkg::cmd_t  cmd,
    output logic            busy
);

    mket_pkg::state_t state_reg;
    mket_pkg::state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mket_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mket_pkg::S_IDLE:
            begin
                if (start && req_type == mket_pkg::REQ_EXTRACT && !stat.empty)
                begin
                    state_next = mket_pkg::S_SCAN;
                end
            end
            mket_pkg::S_SCAN:
            begin
                if (stat.ptr_zero)
                begin
                    state_next = mket_pkg::S_SCAN_END;
                end
            end
            mket_pkg::S_SCAN_END:
            begin
                state_next = mket_pkg::S_SHIFT_INIT;
            end
            mket_pkg::S_SHIFT_INIT:
            begin
                state_next = mket_pkg::S_SHIFT;
            end
            mket_pkg::S_SHIFT:
            begin
                if (!stat.ptr_lt_cnt && !stat.rd_pend)
                begin
                    state_next = mket_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mket_pkg::S_IDLE;
            end
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            mket_pkg::S_IDLE:
            begin
                if (start)
                begin
                    unique case (req_type)
                        mket_pkg::REQ_INSERT:
                        begin
                            cmd.ins      = !stat.full;
                            cmd.res_full = stat.full;
                        end
                        mket_pkg::REQ_EXTRACT:
                        begin
                            cmd.res_empty = stat.empty;
                            cmd.scan_init = !stat.empty;
                        end
                        default:
                        begin
                            cmd = '0;
                        end
                    endcase
                end
            end
            mket_pkg::S_SCAN:
            begin
                cmd.rd_issue = 1'b1;
                cmd.ptr_dec  = 1'b1;
                cmd.cmp_en   = 1'b1;
            end
            mket_pkg::S_SCAN_END:
            begin
                cmd.cmp_en = 1'b1;
            end
            mket_pkg::S_SHIFT_INIT:
            begin
                cmd.shift_init = 1'b1;
            end
            mket_pkg::S_SHIFT:
            begin
                cmd.shift_en = 1'b1;
                if (stat.ptr_lt_cnt)
                begin
                    cmd.rd_issue = 1'b1;
                    cmd.ptr_inc  = 1'b1;
                end
                else if (!stat.rd_pend)
                begin
                    cmd.finish = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign busy = (state_reg != mket_pkg::S_IDLE);

endmodule

>>> rtl/core/mket_dp.sv
`include "max_key_extract_table_top_assert.svh"

module mket_dp #(
    parameter int CAPACITY = 64,
    localparam int CW = $clog2(CAPACITY + 1),
    localparam int AW = $clog2(CAPACITY)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mket_pkg::cmd_t              cmd,
    input  logic [mket_pkg::KEY_W-1:0]  key,
    input  logic [mket_pkg::TAG_W-1:0]  tag,
    output mket_pkg::stat_t             stat,
    output logic                        done,
    output logic [1:0]                  status,
    output logic [mket_pkg::KEY_W-1:0]  out_key,
    output logic [mket_pkg::TAG_W-1:0]  out_tag,
    output logic [6:0]                  entry_count
);

    localparam int EW = mket_pkg::KEY_W + mket_pkg::TAG_W;

    logic [CW-1:0]               cnt_reg;
    logic [CW-1:0]               ptr_reg;
    logic                        rd_vld_reg;
    logic [AW-1:0]               rd_idx_reg;
    logic                        first_reg;
    logic [mket_pkg::KEY_W-1:0]  best_key_reg;
    logic [mket_pkg::TAG_W-1:0]  best_tag_reg;
    logic [AW-1:0]               best_idx_reg;
    logic                        done_reg;
    logic [1:0]                  status_reg;
    logic [mket_pkg::KEY_W-1:0]  out_key_reg;
    logic [mket_pkg::TAG_W-1:0]  out_tag_reg;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [EW-1:0]               ram_wdata;
    logic [EW-1:0]               ram_rdata;
    logic [mket_pkg::KEY_W-1:0]  rd_key;
    logic [mket_pkg::TAG_W-1:0]  rd_tag;
    logic                        take_best;
    logic [CW+6:0]               cnt_ext;

    // Entry store: key in the upper half, tag in the lower
    mket_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ptr_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Select write source: new entry on insert, moved entry while closing the gap
    assign ram_we    = cmd.ins | (cmd.shift_en & rd_vld_reg);
    assign ram_waddr = cmd.ins ? cnt_reg[AW-1:0] : (rd_idx_reg - AW'(1));
    assign ram_wdata = cmd.ins ? {key, tag} : ram_rdata;

    assign rd_key = ram_rdata[EW-1:mket_pkg::TAG_W];
    assign rd_tag = ram_rdata[mket_pkg::TAG_W-1:0];

    // Strictly greater wins, so the newest of equal keys is kept
    assign take_best = cmd.cmp_en & rd_vld_reg & (first_reg | (rd_key > best_key_reg));

    // Report status
    assign stat.full       = (cnt_reg == CW'(CAPACITY));
    assign stat.empty      = (cnt_reg == '0);
    assign stat.ptr_zero   = (ptr_reg == '0);
    assign stat.ptr_lt_cnt = (ptr_reg < cnt_reg);
    assign stat.rd_pend    = rd_vld_reg;

    // Track fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.ins)
        begin
            cnt_reg <= cnt_reg + CW'(1);
        end
        else if (cmd.finish)
        begin
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    // Walk the read pointer: down during the scan, up while shifting
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else if (cmd.scan_init)
        begin
            ptr_reg <= cnt_reg - CW'(1);
        end
        else if (cmd.shift_init)
        begin
            ptr_reg <= CW'(best_idx_reg) + CW'(1);
        end
        else if (cmd.ptr_dec)
        begin
            ptr_reg <= ptr_reg - CW'(1);
        end
        else if (cmd.ptr_inc)
        begin
            ptr_reg <= ptr_reg + CW'(1);
        end
    end

    // Mark which address the read data belongs to
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
            rd_idx_reg <= '0;
        end
        else
        begin
            rd_vld_reg <= cmd.rd_issue;
            if (cmd.rd_issue)
            begin
                rd_idx_reg <= ptr_reg[AW-1:0];
            end
        end
    end

    // Hold the best entry seen so far
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b0;
        end
        else if (cmd.scan_init)
        begin
            first_reg <= 1'b1;
        end
        else if (take_best)
        begin
            first_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_best)
        begin
            best_key_reg <= rd_key;
            best_tag_reg <= rd_tag;
            best_idx_reg <= rd_idx_reg;
        end
    end

    // Register the result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.ins | cmd.res_full | cmd.res_empty | cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ins | cmd.res_full | cmd.res_empty | cmd.finish)
        begin
            out_key_reg <= '0;
            out_tag_reg <= '0;
            if (cmd.ins)
            begin
                status_reg <= mket_pkg::ST_INSERTED;
            end
            else if (cmd.res_full)
            begin
                status_reg <= mket_pkg::ST_FULL;
            end
            else if (cmd.res_empty)
            begin
                status_reg <= mket_pkg::ST_EMPTY;
            end
            else
            begin
                status_reg  <= mket_pkg::ST_EXTRACTED;
                out_key_reg <= best_key_reg;
                out_tag_reg <= best_tag_reg;
            end
        end
    end

    assign cnt_ext     = {7'b0, cnt_reg};
    assign done        = done_reg;
    assign status      = status_reg;
    assign out_key     = out_key_reg;
    assign out_tag     = out_tag_reg;
    assign entry_count = cnt_ext[6:0];

    `MKET_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= CW'(CAPACITY),
        "fill count above capacity")
    `MKET_ASSERT_IMP(a_ins_not_full, cmd.ins, cnt_reg != CW'(CAPACITY),
        "insert into full table")
    `MKET_ASSERT_IMP(a_no_write_in_scan, cmd.cmp_en, !ram_we,
        "store written during scan")
    `MKET_ASSERT_NXT(a_finish_dec, cmd.finish, cnt_reg == $past(cnt_reg) - CW'(1),
        "extract did not drop the count")

endmodule

>>> verif/max_key_extract_table_top_test.sv
`timescale 1ns / 100ps

module max_key_extract_table_top_test;

    import mket_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int RANDOM_ITEMS = 850;
    localparam int SETTLE_CYCLES = 2 * CAPACITY + 16;

    typedef struct {
        logic             req;
        logic [KEY_W-1:0] req_key;
        logic [TAG_W-1:0] req_tag;
        bit               wait_idle;
    } table_req_t;

    typedef struct {
        logic [KEY_W-1:0] ent_key;
        logic [TAG_W-1:0] ent_tag;
    } table_entry_t;

    typedef struct {
        logic [1:0]       status;
        logic [KEY_W-1:0] ext_key;
        logic [TAG_W-1:0] ext_tag;
        logic [6:0]       count;
    } table_reply_t;

    logic             clk = 1'b1;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             req_type = REQ_INSERT;
    logic [KEY_W-1:0] key = '0;
    logic [TAG_W-1:0] tag = '0;
    logic             busy;
    logic             done;
    logic [1:0]       status;
    logic [KEY_W-1:0] out_key;
    logic [TAG_W-1:0] out_tag;
    logic [6:0]       entry_count;

    table_req_t   pending_reqs[$];
    table_entry_t held_entries[$];
    table_reply_t predicted_replies[$];
    int           fail_count = 0;
    int           table_fill = 0;
    int           burst_left = 1;
    int           gap_left = 0;

    max_key_extract_table_top #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .key         (key),
        .tag         (tag),
        .done        (done),
        .status      (status),
        .out_key     (out_key),
        .out_tag     (out_tag),
        .entry_count (entry_count)
    );

    // 50 MHz clock
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Apply one accepted request to the table image and queue its reply
    task automatic model_request(input logic req, input logic [KEY_W-1:0] k,
                                 input logic [TAG_W-1:0] t);
        table_reply_t r;
        table_entry_t e;
        int           best;
        r.ext_key = '0;
        r.ext_tag = '0;
        if (req == REQ_INSERT)
        begin
            if (held_entries.size() >= CAPACITY)
                r.status = ST_FULL;
            else
            begin
                e.ent_key = k;
                e.ent_tag = t;
                held_entries.push_back(e);
                r.status = ST_INSERTED;
            end
        end
        else if (held_entries.size() == 0)
            r.status = ST_EMPTY;
        else
        begin
            // scan newest to oldest; strict compare keeps the newest of equal keys
            best = held_entries.size() - 1;
            for (int i = held_entries.size() - 2; i >= 0; i--)
                if (held_entries[i].ent_key > held_entries[best].ent_key)
                    best = i;
            r.status  = ST_EXTRACTED;
            r.ext_key = held_entries[best].ent_key;
            r.ext_tag = held_entries[best].ent_tag;
            held_entries.delete(best);
        end
        r.count = 7'(held_entries.size());
        predicted_replies.push_back(r);
    endtask

    task automatic report_mismatch(input string field, input logic [KEY_W-1:0] got,
                                   input logic [KEY_W-1:0] want);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
    endtask

    // Queue one request and track the fill level it leaves behind
    task automatic queue_req(input logic req, input logic [KEY_W-1:0] k,
                             input logic [TAG_W-1:0] t, input bit hold_off);
        table_req_t item;
        item.req       = req;
        item.req_key   = k;
        item.req_tag   = t;
        item.wait_idle = hold_off;
        pending_reqs.push_back(item);
        if (req == REQ_INSERT && table_fill < CAPACITY)
            table_fill++;
        else if (req == REQ_EXTRACT && table_fill > 0)
            table_fill--;
    endtask

    // Favor extremes and small values so equal keys show up often
    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2, 3: return KEY_W'($urandom_range(0, 3));
            default: return KEY_W'($urandom);
        endcase
    endfunction

    // Driver: hold a beat until accepted, then advance in bursts with gaps
    always @(posedge clk)
    begin
        table_req_t nxt;
        if (rst_n)
        begin
            if (start && !busy)
                model_request(req_type, key, tag);
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_reqs.size() > 0 &&
                         !(pending_reqs[0].wait_idle && predicted_replies.size() > 0))
                begin
                    nxt = pending_reqs.pop_front();
                    req_type <= nxt.req;
                    key      <= nxt.req_key;
                    tag      <= nxt.req_tag;
                    start    <= 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: check each result beat against the oldest prediction
    always @(posedge clk)
    begin
        table_reply_t want;
        if (rst_n && done)
        begin
            if (predicted_replies.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected result beat: status %0d key %h tag %h count %0d",
                             $time, status, out_key, out_tag, entry_count);
            end
            else
            begin
                want = predicted_replies.pop_front();
                if (status !== want.status)
                    report_mismatch("status", KEY_W'(status), KEY_W'(want.status));
                if (out_key !== want.ext_key)
                    report_mismatch("out_key", out_key, want.ext_key);
                if (out_tag !== want.ext_tag)
                    report_mismatch("out_tag", out_tag, want.ext_tag);
                if (entry_count !== want.count)
                    report_mismatch("entry_count", KEY_W'(entry_count), KEY_W'(want.count));
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        int  random_count;
        int  phase;
        int  n;
        int  extract_pct;
        bit  first_phase;
        bit  hold_off;

        // extract from an empty table
        queue_req(REQ_EXTRACT, '0, '0, 1'b0);
        // extreme keys and tags, equal keys at both ends of the table
        queue_req(REQ_INSERT, 16'hFFFF, 16'h0000, 1'b0);
        queue_req(REQ_INSERT, 16'h0000, 16'hFFFF, 1'b0);
        queue_req(REQ_INSERT, 16'h8000, 16'h1234, 1'b0);
        queue_req(REQ_INSERT, 16'h8000, 16'h5678, 1'b0);
        queue_req(REQ_INSERT, 16'hFFFF, 16'hAAAA, 1'b0);
        repeat (5)
            queue_req(REQ_EXTRACT, 16'hFFFF, 16'hFFFF, 1'b0);
        queue_req(REQ_EXTRACT, '0, '0, 1'b0);
        queue_req(REQ_INSERT, 16'h0001, 16'h5555, 1'b0);
        queue_req(REQ_INSERT, 16'h0001, 16'h2AAA, 1'b0);
        queue_req(REQ_INSERT, 16'h7FFF, 16'h8001, 1'b0);
        repeat (4)
            queue_req(REQ_EXTRACT, '0, '0, 1'b0);

        // random phases; the first one fills the table past full after a pause
        random_count = 0;
        first_phase  = 1'b1;
        while (random_count < RANDOM_ITEMS)
        begin
            phase = first_phase ? 0 : $urandom_range(0, 3);
            hold_off = first_phase || ($urandom_range(0, 3) == 0);
            first_phase = 1'b0;
            case (phase)
                0:
                begin
                    n = CAPACITY - table_fill + $urandom_range(1, 3);
                    repeat (n)
                    begin
                        queue_req(REQ_INSERT, pick_key(), TAG_W'($urandom), hold_off);
                        hold_off = 1'b0;
                    end
                end
                1:
                begin
                    n = table_fill + $urandom_range(1, 2);
                    repeat (n)
                    begin
                        queue_req(REQ_EXTRACT, KEY_W'($urandom), TAG_W'($urandom), hold_off);
                        hold_off = 1'b0;
                    end
                end
                default:
                begin
                    n = $urandom_range(10, 40);
                    extract_pct = $urandom_range(20, 80);
                    repeat (n)
                    begin
                        queue_req(($urandom_range(0, 99) < extract_pct) ? REQ_EXTRACT
                                                                        : REQ_INSERT,
                                  pick_key(), TAG_W'($urandom), hold_off);
                        hold_off = 1'b0;
                    end
                end
            endcase
            random_count += n;
        end

        // hold reset, then release it
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;

        // drain: every beat accepted and every result seen, then settle
        while (pending_reqs.size() != 0 || start || predicted_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        if (predicted_replies.size() != 0)
        begin
            fail_count += predicted_replies.size();
            $display("%0d expected results never arrived", predicted_replies.size());
        end
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/mket_pkg.sv
rtl/core/mket_ram.sv
rtl/core/mket_ctrl.sv
rtl/core/mket_dp.sv
rtl/core/max_key_extract_table_top.sv
verif/max_key_extract_table_top_test.sv
